@@ sv/base64_stream_decoder_defines.svh @@
// Assertion macros used by the decoder top level.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64sd: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64sd: next-cycle check failed");

`endif

@@ sv/b64sd_pkg.sv @@
package b64sd_pkg;

    // Character classes
    localparam logic [1:0] CLS_SKIP = 2'd0;
    localparam logic [1:0] CLS_PAD  = 2'd1;
    localparam logic [1:0] CLS_DATA = 2'd2;
    localparam logic [1:0] CLS_BAD  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [15:0]       MAX_OUT_RESET = 16'hFFFF;
    localparam logic signed [3:0] PEND_RESET    = -4'sd8;
    localparam logic signed [3:0] SEXTET_BITS   = 4'sd6;

    typedef struct packed {
        logic [1:0] cls;
        logic [5:0] sextet;
    } t_class;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } t_result;

endpackage

@@ sv/b64sd_classify.sv @@
module b64sd_classify
    import b64sd_pkg::*;
(
    input  logic [7:0] i_char,
    output t_class     o_class
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [7:0] OFS_LOWER = 8'd26;
    localparam logic [7:0] OFS_DIGIT = 8'd52;
    localparam logic [5:0] SX_PLUS   = 6'd62;
    localparam logic [5:0] SX_SLASH  = 6'd63;

    always_comb begin
        o_class.cls    = CLS_BAD;
        o_class.sextet = '0;
        if (i_char >= CH_UA && i_char <= CH_UZ) begin
            o_class.cls    = CLS_DATA;
            o_class.sextet = 6'(i_char - CH_UA);
        end else if (i_char >= CH_LA && i_char <= CH_LZ) begin
            o_class.cls    = CLS_DATA;
            o_class.sextet = 6'(i_char - CH_LA + OFS_LOWER);
        end else if (i_char >= CH_0 && i_char <= CH_9) begin
            o_class.cls    = CLS_DATA;
            o_class.sextet = 6'(i_char - CH_0 + OFS_DIGIT);
        end else if (i_char == CH_PLUS) begin
            o_class.cls    = CLS_DATA;
            o_class.sextet = SX_PLUS;
        end else if (i_char == CH_SLASH) begin
            o_class.cls    = CLS_DATA;
            o_class.sextet = SX_SLASH;
        end else if (i_char == CH_EQ) begin
            o_class.cls = CLS_PAD;
        end else if (i_char == CH_SPACE || i_char == CH_TAB ||
                     i_char == CH_CR || i_char == CH_LF) begin
            o_class.cls = CLS_SKIP;
        end
    end

endmodule

@@ sv/b64sd_step.sv @@
module b64sd_step
    import b64sd_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  t_class                  i_class,
    input  logic                    i_last,
    input  logic [15:0]             i_max_out,
    input  logic [11:0]             i_acc,
    input  logic signed [3:0]       i_pend,
    input  logic [COUNT_BITS-1:0]   i_cnt,
    input  logic                    i_stopped,
    input  logic [1:0]              i_err,
    output logic [11:0]             o_acc,
    output logic signed [3:0]       o_pend,
    output logic [COUNT_BITS-1:0]   o_cnt,
    output logic                    o_stopped,
    output logic [1:0]              o_err,
    output t_result                 o_result
);

    localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic                  w_active;
    logic [11:0]           w_acc_sh;
    logic signed [3:0]     w_pend_add;
    logic [EXT_BITS-1:0]   w_cnt_ext;
    logic [EXT_BITS-1:0]   w_max_ext;
    logic                  w_full;
    logic [11:0]           w_acc;
    logic signed [3:0]     w_pend;
    logic [COUNT_BITS-1:0] w_cnt;
    logic                  w_stopped;
    logic [1:0]            w_err;
    logic [7:0]            w_byte;
    logic                  w_valid;
    logic [EXT_BITS-1:0]   w_cnt_out;

    assign w_active   = !i_stopped && (i_err == ST_OK);
    assign w_acc_sh   = {i_acc[5:0], i_class.sextet};
    assign w_pend_add = i_pend + SEXTET_BITS;
    assign w_cnt_ext  = EXT_BITS'(i_cnt);
    assign w_max_ext  = EXT_BITS'(i_max_out);
    assign w_full     = (w_cnt_ext >= w_max_ext) || (i_cnt == '1);

    always_comb begin
        w_acc     = i_acc;
        w_pend    = i_pend;
        w_cnt     = i_cnt;
        w_stopped = i_stopped;
        w_err     = i_err;
        w_byte    = '0;
        w_valid   = 1'b0;
        if (w_active) begin
            case (i_class.cls)
                CLS_SKIP: begin
                end
                CLS_PAD: begin
                    w_stopped = 1'b1;
                end
                CLS_DATA: begin
                    w_acc  = w_acc_sh;
                    w_pend = w_pend_add;
                    if (!w_pend_add[3]) begin
                        if (w_full) begin
                            w_err = ST_OVF;
                        end else begin
                            w_byte  = 8'(w_acc_sh >> w_pend_add[2:0]);
                            w_valid = 1'b1;
                            w_cnt   = i_cnt + COUNT_BITS'(1);
                            w_pend  = w_pend_add - 4'sd8;
                        end
                    end
                end
                default: begin
                    w_err = ST_BAD;
                end
            endcase
        end
    end

    assign w_cnt_out = EXT_BITS'(w_cnt);

    always_comb begin
        o_result.out_byte   = w_byte;
        o_result.byte_valid = w_valid;
        o_result.done_res   = i_last;
        o_result.status     = w_err;
        o_result.byte_count = (w_err != ST_OK) ? 16'd0 : w_cnt_out[15:0];
    end

    // Return to the start state after the last character of a message
    always_comb begin
        if (i_last) begin
            o_acc     = '0;
            o_pend    = PEND_RESET;
            o_cnt     = '0;
            o_stopped = 1'b0;
            o_err     = ST_OK;
        end else begin
            o_acc     = w_acc;
            o_pend    = w_pend;
            o_cnt     = w_cnt;
            o_stopped = w_stopped;
            o_err     = w_err;
        end
    end

endmodule

@@ sv/base64_stream_decoder.sv @@
// base64_stream_decoder: decodes a base64 character stream, one character per
// transaction on the input channel (i_in_valid / o_in_ready, i_in_char, i_last).
// Every input transaction yields exactly one result transaction on the output
// channel (o_out_valid / i_out_ready): an optional decoded byte, the last flag,
// the message status and the running byte count.
// Whitespace is skipped, the first '=' stops decoding until the message ends,
// other non-alphabet characters latch a bad-character error, and a byte beyond
// the max_out capacity latches an overflow error.
// Capacity is written on the config channel (i_cfg_valid / o_cfg_ready,
// i_cfg_max_out), always ready; write it only while no message is in flight.
// A result passes through the input register and then the output register
// before it can be taken on the output channel.
// Throughput: one character per clock unless the receiver stalls; the decode is
// a single registered pass. A stalled receiver holds the output register; the
// input register then fills and o_in_ready drops until the result is taken.
// Reset (synchronous, active low) empties both registers, clears the message
// state and sets the capacity to 65535.
`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder
    import b64sd_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_char,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [15:0] o_byte_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_out
);

    // Configuration
    logic [15:0] r_max_out;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    // Message state
    logic [11:0]           r_acc,     n_acc;
    logic signed [3:0]     r_pend,    n_pend;
    logic [COUNT_BITS-1:0] r_cnt,     n_cnt;
    logic                  r_stopped, n_stopped;
    logic [1:0]            r_err,     n_err;

    // Output register
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;

    t_class  w_class;
    logic    w_advance;

    // Checker terms
    logic    w_out_has_byte;
    logic    w_out_err;
    logic    w_at_start;

    // Move the held character into the output register when that slot frees up
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    b64sd_classify u_classify (
        .i_char  (r_in_char),
        .o_class (w_class)
    );

    b64sd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_class   (w_class),
        .i_last    (r_in_last),
        .i_max_out (r_max_out),
        .i_acc     (r_acc),
        .i_pend    (r_pend),
        .i_cnt     (r_cnt),
        .i_stopped (r_stopped),
        .i_err     (r_err),
        .o_acc     (n_acc),
        .o_pend    (n_pend),
        .o_cnt     (n_cnt),
        .o_stopped (n_stopped),
        .o_err     (n_err),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out <= MAX_OUT_RESET;
        end else if (i_cfg_valid) begin
            r_max_out <= i_cfg_max_out;
        end
    end

    // Input register: load on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_in_char;
            r_in_last <= i_last;
        end
    end

    // Message state: advance once per decoded character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pend    <= PEND_RESET;
            r_cnt     <= '0;
            r_stopped <= 1'b0;
            r_err     <= ST_OK;
        end else if (w_advance) begin
            r_acc     <= n_acc;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
            r_err     <= n_err;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_result.out_byte;
    assign o_byte_valid = r_result.byte_valid;
    assign o_done_res   = r_result.done_res;
    assign o_status     = r_result.status;
    assign o_byte_count = r_result.byte_count;

    assign w_out_has_byte = r_out_valid && r_result.byte_valid;
    assign w_out_err      = r_out_valid && (r_result.status != ST_OK);
    assign w_at_start     = (r_cnt == '0) && (r_err == ST_OK) && !r_stopped &&
                            (r_pend == PEND_RESET);

    // A decoded byte only ever comes with a clean status
    `B64SD_ASSERT_NOW(a_byte_ok, i_clk, i_rst_n, w_out_has_byte, r_result.status == ST_OK)
    // An error status always reports a zero count
    `B64SD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, w_out_err, r_result.byte_count == 16'd0)
    // The last character of a message returns the state to start
    `B64SD_ASSERT_NEXT(a_last_clear, i_clk, i_rst_n, w_advance && r_in_last, w_at_start)

endmodule

@@ tb/tb_base64_stream_decoder.sv @@
module tb_base64_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import b64sd_pkg::*;

    // Characters with a role of their own in the decoder.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    localparam int COUNT_MAX      = (1 << 16) - 1;
    localparam int IDLE_PCT       = 6;
    localparam int DRAIN_CYCLES   = 4;      // two register stages plus margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int QUIET_ITEMS    = 150;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_char     = 8'h00;
    logic        i_last        = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic [15:0] o_byte_count;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_max_out = 16'h0000;

    base64_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_char     (i_in_char),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_done_res    (o_done_res),
        .o_status      (o_status),
        .o_byte_count  (o_byte_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_max_out (i_cfg_max_out)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder shadow state: mirrors the message state inside the block and
    // advances once per accepted input transaction.
    // ------------------------------------------------------------------
    logic [15:0] cap_max_out = MAX_OUT_RESET;
    logic [11:0] acc_bits    = '0;
    int          pend_bits   = -8;
    int          byte_total  = 0;
    logic        halted      = 1'b0;   // set by the first pad of a message
    logic [1:0]  err_code    = ST_OK;

    t_result     expected_decodes[$];
    int          mismatches  = 0;
    int          chars_sent  = 0;
    bit          no_idle     = 1'b0;   // suppress idling on both sides
    int          stall_cycles = 0;

    // Sort a character into skip, pad, data or bad, with its 6-bit value.
    function automatic t_class classify(logic [7:0] ch);
        t_class c;
        c.cls    = CLS_BAD;
        c.sextet = '0;
        if (ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
            c.cls = CLS_SKIP;
        end else if (ch == CH_PAD) begin
            c.cls = CLS_PAD;
        end else if (ch >= "A" && ch <= "Z") begin
            c.cls    = CLS_DATA;
            c.sextet = 6'(ch - "A");
        end else if (ch >= "a" && ch <= "z") begin
            c.cls    = CLS_DATA;
            c.sextet = 6'(ch - "a" + 26);
        end else if (ch >= "0" && ch <= "9") begin
            c.cls    = CLS_DATA;
            c.sextet = 6'(ch - "0" + 52);
        end else if (ch == "+") begin
            c.cls    = CLS_DATA;
            c.sextet = 6'd62;
        end else if (ch == "/") begin
            c.cls    = CLS_DATA;
            c.sextet = 6'd63;
        end
        return c;
    endfunction

    // Advance the shadow state by one character and return the result it causes.
    function automatic t_result decode_char(logic [7:0] ch, logic lst);
        t_class  c;
        t_result r;
        c = classify(ch);
        r = '0;
        // Ignore everything after a pad or an error until the message ends.
        if (!halted && err_code == ST_OK) begin
            case (c.cls)
                CLS_PAD: begin
                    halted = 1'b1;
                end
                CLS_BAD: begin
                    err_code = ST_BAD;
                end
                CLS_DATA: begin
                    acc_bits  = {acc_bits[5:0], c.sextet};
                    pend_bits = pend_bits + 6;
                    if (pend_bits >= 0) begin
                        // Latch overflow instead of emitting a byte past capacity.
                        if (byte_total >= cap_max_out || byte_total >= COUNT_MAX) begin
                            err_code = ST_OVF;
                        end else begin
                            r.out_byte   = 8'(acc_bits >> pend_bits);
                            r.byte_valid = 1'b1;
                            byte_total   = byte_total + 1;
                            pend_bits    = pend_bits - 8;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.done_res   = lst;
        r.status     = err_code;
        r.byte_count = (err_code != ST_OK) ? 16'd0 : 16'(byte_total);
        // Return to the start state once the message closes.
        if (lst) begin
            acc_bits   = '0;
            pend_bits  = -8;
            byte_total = 0;
            halted     = 1'b0;
            err_code   = ST_OK;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (mismatches < REPORT_LIMIT) begin
                $display("mismatch in %s: expected %0d, got %0d (t=%0t)", name, want, got,
                         $realtime);
            end
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: check results first, then predict newly accepted input,
    // then track register writes. The two register stages keep a result from
    // leaving in the same cycle its input is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_decodes.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("unexpected result: byte %0d valid %0d done %0d status %0d",
                                 o_out_byte, o_byte_valid, o_done_res, o_status);
                    end
                    mismatches++;
                end else begin
                    want = expected_decodes.pop_front();
                    check_field("out_byte",   want.out_byte,   o_out_byte);
                    check_field("byte_valid", want.byte_valid, o_byte_valid);
                    check_field("done_res",   want.done_res,   o_done_res);
                    check_field("status",     want.status,     o_status);
                    check_field("byte_count", want.byte_count, o_byte_count);
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_decodes.push_back(decode_char(i_in_char, i_last));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cap_max_out = i_cfg_max_out;
            end
        end
    end

    // Watchdog: end the run when no channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** base64_stream_decoder: FAILED **");
            $finish;
        end
    end

    // Receiver: stall now and then, never during a quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one character and hold it until the block takes it. Leave valid
    // high on return so back-to-back characters keep the channel busy.
    task automatic send_char(input logic [7:0] ch, input logic lst);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= ch;
        i_last     <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    // Send a whole message; flag the final character as last.
    task automatic send_message(input logic [7:0] chars[$]);
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    // Drop valid, let the scoreboard see the last transaction, wait for every
    // result, then let the pipeline settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the capacity register between messages only.
    task automatic write_max_out(input logic [15:0] cap);
        wait_drained();
        i_cfg_valid   <= 1'b1;
        i_cfg_max_out <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] sextet_char(logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Build and send a message of n_data data characters plus random blanks. noise_pct replaces
    // characters with arbitrary codes; padding and trailing junk are random.
    task automatic send_random_message(input int n_data, input int noise_pct);
        logic [7:0] msg[$];
        for (int i = 0; i < n_data; i++) begin
            if ($urandom_range(99) < 8) msg.push_back(blank_char());
            if ($urandom_range(99) < noise_pct) begin
                msg.push_back(8'($urandom_range(255)));
            end else begin
                msg.push_back(sextet_char(6'($urandom_range(63))));
            end
        end
        if ($urandom_range(1)) begin
            msg.push_back(CH_PAD);
            if ($urandom_range(1)) msg.push_back(CH_PAD);
            // Append junk after the pad; all of it must be ignored.
            if ($urandom_range(99) < 30) begin
                repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(99) < 10) msg.push_back(blank_char());
        if (msg.size() == 0) msg.push_back(blank_char());
        send_message(msg);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked messages: alphabet extremes, whitespace, pad handling,
    // invalid codes high and low, and a message that decodes nothing.
    task automatic test_directed();
        logic [7:0] msg[$];
        msg = '{"T", "W", "F", "u"};
        send_message(msg);
        msg = '{CH_SPACE, "A", "Z", CH_TAB, "a", "z"};
        send_message(msg);
        msg = '{"0", "9", "+", "/", CH_PAD, "Q", CH_PAD, CH_LF};
        send_message(msg);
        msg = '{CH_LF};
        send_message(msg);
        msg = '{"Q", "Q", 8'h80, "Q", 8'hFF};
        send_message(msg);
        msg = '{8'h00};
        send_message(msg);
    endtask

    // Hit the capacity limit at the extremes and a few small settings.
    task automatic test_capacity();
        logic [15:0] caps[$];
        caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'($urandom_range(4, 40)), 16'hFFFF};
        foreach (caps[i]) begin
            write_max_out(caps[i]);
            repeat (2) begin
                send_random_message((caps[i] > 40 ? 8 : caps[i] * 4 / 3) +
                                    $urandom_range(0, 6), 0);
            end
        end
    endtask

    // Mostly well-formed messages with random content, some noisy ones, and
    // an occasional capacity change between messages.
    task automatic test_random_messages();
        int start;
        start = chars_sent;
        while (chars_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 5) begin
                case ($urandom_range(3))
                    0:       write_max_out(16'd0);
                    1:       write_max_out(16'($urandom_range(0, 20)));
                    2:       write_max_out(16'hFFFF);
                    default: write_max_out(16'($urandom_range(0, 65535)));
                endcase
            end
            if ($urandom_range(99) < 85) begin
                send_random_message(($urandom_range(99) < 10) ? $urandom_range(25, 60)
                                                              : $urandom_range(0, 24), 0);
            end else begin
                send_random_message($urandom_range(0, 30), 15);
            end
        end
    endtask

    // Full-rate stretch: no idling on either side.
    task automatic test_back_to_back();
        int start;
        write_max_out(16'hFFFF);
        no_idle = 1'b1;
        start   = chars_sent;
        while (chars_sent - start < QUIET_ITEMS) begin
            send_random_message($urandom_range(0, 24), 5);
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    initial begin
        // Hold reset once, at the start of the run.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_random_messages();
        test_back_to_back();

        wait_drained();
        if (mismatches == 0) begin
            $display("** base64_stream_decoder: PASSED **");
        end else begin
            $display("** base64_stream_decoder: FAILED **");
        end
        $finish;
    end

endmodule
